// ===== rtl/core/sreh_pkg.sv =====
// ----------------------------------------------------------------------------
// sreh_pkg
// Types and constants shared by the segment / rectangle edge hit pipeline.
// ----------------------------------------------------------------------------
package sreh_pkg;

	localparam int COORD_BITS = 32;
	localparam int DW         = COORD_BITS + 1;   // coordinate difference width
	localparam int PW         = 2 * DW;           // product width
	localparam int NL         = 4;                // one lane per rectangle edge
	localparam int IDX_BITS   = 8;

	localparam logic [IDX_BITS-1:0] REG_X_MIN = 8'd0;
	localparam logic [IDX_BITS-1:0] REG_X_MAX = 8'd1;
	localparam logic [IDX_BITS-1:0] REG_Y_MIN = 8'd2;
	localparam logic [IDX_BITS-1:0] REG_Y_MAX = 8'd3;

	typedef enum logic [1:0] {
		EDGE_LEFT   = 2'd0,
		EDGE_RIGHT  = 2'd1,
		EDGE_BOTTOM = 2'd2,
		EDGE_TOP    = 2'd3
	} edge_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
	} seg_t;

	typedef struct packed {
		logic                         found;
		logic signed [COORD_BITS-1:0] hit_x;
		logic signed [COORD_BITS-1:0] hit_y;
		logic [1:0]                   edge_res;
	} hit_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_min;
		logic signed [COORD_BITS-1:0] x_max;
		logic signed [COORD_BITS-1:0] y_min;
		logic signed [COORD_BITS-1:0] y_max;
	} cfg_t;

	// per-edge side data that rides along with the division
	typedef struct packed {
		logic                  qual;   // edge lies strictly inside the span
		logic                  neg;    // sign of the quotient
		logic [COORD_BITS-1:0] base;   // start coordinate of the interpolation
		logic [COORD_BITS-1:0] ev;     // edge coordinate
	} lane_t;

	typedef struct packed {
		logic              dxz;        // segment is vertical
		lane_t [NL-1:0]    lane;
	} side_t;

endpackage

// ===== rtl/core/sreh_prep.sv =====
// ----------------------------------------------------------------------------
// sreh_prep
// Span tests, deltas and magnitudes (s1), then the four products (s2).
// ----------------------------------------------------------------------------
module sreh_prep import sreh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid,
	input  seg_t                seg,
	input  cfg_t                cfg,
	output logic                valid_o,
	output logic [PW-1:0]       num_o [NL],
	output logic [DW-1:0]       den_o [NL],
	output side_t               side_o
);

	logic              valid_s1;
	side_t             side_s1;
	logic [DW-1:0]     m1_s1 [NL];
	logic [DW-1:0]     m2_s1 [NL];
	logic [DW-1:0]     den_s1 [NL];

	logic              valid_s2;
	side_t             side_s2;
	logic [PW-1:0]     num_s2 [NL];
	logic [DW-1:0]     den_s2 [NL];

	side_t             side_c;
	logic [DW-1:0]     m1_c [NL];
	logic [DW-1:0]     m2_c [NL];
	logic [DW-1:0]     den_c [NL];

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		mag = v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	always_comb begin
		logic signed [DW-1:0] axe, aye, bxe, bye, dx, dy, sv, sh;
		logic signed [COORD_BITS-1:0] lox, hix, loy, hiy, e;
		logic [COORD_BITS-1:0] ex [NL];
		axe = {seg.ax[COORD_BITS-1], seg.ax};
		aye = {seg.ay[COORD_BITS-1], seg.ay};
		bxe = {seg.bx[COORD_BITS-1], seg.bx};
		bye = {seg.by[COORD_BITS-1], seg.by};
		dx  = bxe - axe;
		dy  = bye - aye;
		lox = (seg.ax < seg.bx) ? seg.ax : seg.bx;
		hix = (seg.ax < seg.bx) ? seg.bx : seg.ax;
		loy = (seg.ay < seg.by) ? seg.ay : seg.by;
		hiy = (seg.ay < seg.by) ? seg.by : seg.ay;
		ex[0] = cfg.x_min;
		ex[1] = cfg.x_max;
		ex[2] = cfg.y_min;
		ex[3] = cfg.y_max;
		side_c.dxz = (dx == '0);
		for (int k = 0; k < NL; k++) begin
			e = $signed(ex[k]);
			if (k < 2) begin
				// vertical edge: y = ay + dy * (e - ax) / dx
				sv = {e[COORD_BITS-1], e} - axe;
				side_c.lane[k].qual = (e > lox) && (e < hix);
				side_c.lane[k].neg  = dy[DW-1] ^ sv[DW-1] ^ dx[DW-1];
				side_c.lane[k].base = seg.ay;
				m1_c[k]  = mag(dy);
				m2_c[k]  = mag(sv);
				den_c[k] = mag(dx);
			end else begin
				// horizontal edge: x = ax + dx * (e - ay) / dy
				sh = {e[COORD_BITS-1], e} - aye;
				side_c.lane[k].qual = (e > loy) && (e < hiy);
				side_c.lane[k].neg  = dx[DW-1] ^ sh[DW-1] ^ dy[DW-1];
				side_c.lane[k].base = seg.ax;
				m1_c[k]  = mag(dx);
				m2_c[k]  = mag(sh);
				den_c[k] = mag(dy);
			end
			side_c.lane[k].ev = ex[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			side_s2 <= side_s1;
			for (int k = 0; k < NL; k++) begin
				m1_s1[k]  <= m1_c[k];
				m2_s1[k]  <= m2_c[k];
				den_s1[k] <= den_c[k];
				num_s2[k] <= PW'(m1_s1[k]) * PW'(m2_s1[k]);
				den_s2[k] <= den_s1[k];
			end
		end
	end

	assign valid_o = valid_s2;
	assign num_o   = num_s2;
	assign den_o   = den_s2;
	assign side_o  = side_s2;

endmodule

// ===== rtl/core/sreh_div.sv =====
// ----------------------------------------------------------------------------
// sreh_div
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// The quotient of a qualified lane is known to fit in DW bits.
// ----------------------------------------------------------------------------
module sreh_div import sreh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid,
	input  logic [PW-1:0]       num [NL],
	input  logic [DW-1:0]       den [NL],
	input  side_t               side,
	output logic                valid_o,
	output logic [DW-1:0]       quo_o [NL],
	output side_t               side_o
);

	logic              v_s    [DW];
	side_t             side_s [DW];
	logic [DW-1:0]     rem_s  [DW][NL];
	logic [DW-1:0]     low_s  [DW][NL];
	logic [DW-1:0]     quo_s  [DW][NL];
	logic [DW-1:0]     den_s  [DW][NL];

	logic [DW-1:0]     rem_n  [DW][NL];
	logic [DW-1:0]     low_n  [DW][NL];
	logic [DW-1:0]     quo_n  [DW][NL];

	always_comb begin
		logic [DW-1:0] r, l, q, d;
		logic [DW:0]   t, df;
		for (int st = 0; st < DW; st++) begin
			for (int k = 0; k < NL; k++) begin
				if (st == 0) begin
					r = num[k][PW-1:DW];
					l = num[k][DW-1:0];
					q = '0;
					d = den[k];
				end else begin
					r = rem_s[st-1][k];
					l = low_s[st-1][k];
					q = quo_s[st-1][k];
					d = den_s[st-1][k];
				end
				t  = {r, l[DW-1]};
				df = t - {1'b0, d};
				if (t >= {1'b0, d}) begin
					rem_n[st][k] = df[DW-1:0];
					quo_n[st][k] = {q[DW-2:0], 1'b1};
				end else begin
					rem_n[st][k] = t[DW-1:0];
					quo_n[st][k] = {q[DW-2:0], 1'b0};
				end
				low_n[st][k] = {l[DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 0; st < DW; st++) v_s[st] <= 1'b0;
		end else if (en) begin
			v_s[0] <= valid;
			for (int st = 1; st < DW; st++) v_s[st] <= v_s[st-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side;
			for (int st = 1; st < DW; st++) side_s[st] <= side_s[st-1];
			for (int st = 0; st < DW; st++) begin
				for (int k = 0; k < NL; k++) begin
					rem_s[st][k] <= rem_n[st][k];
					low_s[st][k] <= low_n[st][k];
					quo_s[st][k] <= quo_n[st][k];
					den_s[st][k] <= (st == 0) ? den[k] : den_s[st-1][k];
				end
			end
		end
	end

	assign valid_o = v_s[DW-1];
	assign quo_o   = quo_s[DW-1];
	assign side_o  = side_s[DW-1];

endmodule

// ===== rtl/core/sreh_pick.sv =====
// ----------------------------------------------------------------------------
// sreh_pick
// Offset the quotients, test the hit points and take the first edge in order.
// ----------------------------------------------------------------------------
module sreh_pick import sreh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid,
	input  logic [DW-1:0]       quo [NL],
	input  side_t               side,
	input  cfg_t                cfg,
	output logic                valid_o,
	output hit_t                hit_o
);

	logic  valid_s;
	hit_t  hit_s;
	hit_t  hit_c;

	always_comb begin
		logic signed [DW:0]           qe, off, sum;
		logic signed [COORD_BITS-1:0] v, xl, xh, yl, yh;
		logic                         ok;
		xl = cfg.x_min;
		xh = cfg.x_max;
		yl = cfg.y_min;
		yh = cfg.y_max;
		hit_c = '0;
		// walk from the top edge down so the lowest qualifying edge wins
		for (int k = NL - 1; k >= 0; k--) begin
			qe  = {1'b0, quo[k]};
			off = side.lane[k].neg ? -qe : qe;
			sum = {{2{side.lane[k].base[COORD_BITS-1]}}, side.lane[k].base} + off;
			v   = sum[COORD_BITS-1:0];
			if (k < 2) ok = (v > yl) && (v < yh);
			else       ok = side.dxz || ((v > xl) && (v < xh));
			if (side.lane[k].qual && ok) begin
				hit_c.found    = 1'b1;
				hit_c.edge_res = 2'(k);
				if (k < 2) begin
					hit_c.hit_x = side.lane[k].ev;
					hit_c.hit_y = v;
				end else begin
					hit_c.hit_x = v;
					hit_c.hit_y = side.lane[k].ev;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s <= hit_c;
		end
	end

	assign valid_o = valid_s;
	assign hit_o   = hit_s;

endmodule

// ===== rtl/core/segment_rectangle_edge_hit.sv =====
// ----------------------------------------------------------------------------
// segment_rectangle_edge_hit
// First crossing, in edge order, of a segment with the edges of a configured view rectangle.
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer when
//  ---------+----------------------------------+-------------------------
//  seg      | seg_valid, seg_stall, seg        | seg_valid & !seg_stall
//  hit      | hit_valid, hit_stall, hit        | hit_valid & !hit_stall
//  cfg      | cfg_valid, cfg_ready, cfg_index, | cfg_valid & cfg_ready
//           | cfg_data                         |
//
// One segment enters per cycle while seg_stall is low; each result passes
// through one stage of span tests, one multiply stage, 33 divider stages
// (one quotient bit each) and the output register.
// Reset clears all valid bits and the rectangle registers to zero.
// A stalled result holds the whole pipeline; seg_stall follows it.
// ----------------------------------------------------------------------------
module segment_rectangle_edge_hit import sreh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  seg_valid,
	output logic                  seg_stall,
	input  seg_t                  seg,
	output logic                  hit_valid,
	input  logic                  hit_stall,
	output hit_t                  hit,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_BITS-1:0]   cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data
);

	cfg_t           cfg_q;
	logic           en;

	logic           p_valid;
	logic [PW-1:0]  p_num [NL];
	logic [DW-1:0]  p_den [NL];
	side_t          p_side;

	logic           d_valid;
	logic [DW-1:0]  d_quo [NL];
	side_t          d_side;

	// advance everything unless a finished result is held back
	assign en        = !(hit_valid && hit_stall);
	assign seg_stall = !en;
	assign cfg_ready = 1'b1;

	// rectangle registers; unused indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_MIN: cfg_q.x_min <= cfg_data;
				REG_X_MAX: cfg_q.x_max <= cfg_data;
				REG_Y_MIN: cfg_q.y_min <= cfg_data;
				REG_Y_MAX: cfg_q.y_max <= cfg_data;
				default: ;
			endcase
		end
	end

	// span tests, deltas, products
	sreh_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (seg_valid && !seg_stall),
		.seg     (seg),
		.cfg     (cfg_q),
		.valid_o (p_valid),
		.num_o   (p_num),
		.den_o   (p_den),
		.side_o  (p_side)
	);

	// four interpolation quotients, one bit per stage
	sreh_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (p_valid),
		.num     (p_num),
		.den     (p_den),
		.side    (p_side),
		.valid_o (d_valid),
		.quo_o   (d_quo),
		.side_o  (d_side)
	);

	// range tests and edge priority into the output register
	sreh_pick u_pick (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (d_valid),
		.quo     (d_quo),
		.side    (d_side),
		.cfg     (cfg_q),
		.valid_o (hit_valid),
		.hit_o   (hit)
	);

endmodule
